/* design/csub_pkg.sv */
// Shared types, constants and helpers for the caseless substring search block.
package csub_pkg;

	localparam int MAX_PATTERN_CHARS = 16;
	localparam int POSITION_BITS     = 16;
	localparam int LEN_BITS          = $clog2(MAX_PATTERN_CHARS + 1);
	localparam int IDX_BITS          = $clog2(MAX_PATTERN_CHARS);
	localparam int CFG_DATA_BITS     = 64;
	localparam int CFG_INDEX_BITS    = 2;
	localparam logic [7:0] CASE_BIT  = 8'h20;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_PATTERN_LEN  = 2'd2
	} cfg_reg_t;

	typedef logic [MAX_PATTERN_CHARS-1:0][7:0] char_vec_t;
	typedef logic [LEN_BITS-1:0] len_t;

	typedef struct packed {
		logic [7:0] source_char;
		logic       last_char;
	} src_word_t;

	typedef struct packed {
		logic                     found;
		logic [POSITION_BITS-1:0] match_position;
		logic                     length_overflow;
	} res_word_t;

	function automatic logic csub_is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic csub_chars_equal(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		x = a ^ b;
		return (x == 8'h00) || (csub_is_letter(a) && csub_is_letter(b) && (x == CASE_BIT));
	endfunction

endpackage

/* design/caseless_substring_search.sv */
// Top level of the caseless substring search block.
//
// Source bytes arrive one word per cycle on the src channel (valid/ready),
// last_char set on the final byte of a string. The block finds the first
// 1-based start of the configured pattern, letters compared without case.
// One result word leaves on the res channel for each string, carrying
// found, match_position (0 when not found) and length_overflow.
// Latency: the result word is valid the cycle after the last byte is taken.
// Throughput: one byte per cycle while res is not stalled; the window compare is a single parallel
// stage between the byte window and the result register.
// The result register holds one word: a byte is taken in the cycle a held
// result leaves, but while a held result is not taken, no new byte is
// accepted, so a stall on res stops src behind that one pending word.
// Configuration: cfg_we writes cfg_data to register cfg_index at once
// (pattern low bytes, pattern high bytes, pattern length); index 3 is
// ignored. Write only between strings or while idle.
// Reset clears the pattern registers, the per-string counters and the
// result valid flag; the byte window is not cleared and needs no pass.
module caseless_substring_search (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   src_valid,
	output logic                                   src_ready,
	input  csub_pkg::src_word_t                    src_word,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output csub_pkg::res_word_t                    res_word,
	input  logic                                   cfg_we,
	input  logic [csub_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [csub_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import csub_pkg::*;

	logic [CFG_DATA_BITS-1:0] pat_low_q;
	logic [CFG_DATA_BITS-1:0] pat_high_q;
	len_t                     pat_len_q;

	char_vec_t                window_q;
	logic [POSITION_BITS-1:0] chars_q;
	logic                     latched_q;
	logic [POSITION_BITS-1:0] start_q;
	logic                     sat_q;

	logic                     res_valid_q;
	res_word_t                res_word_q;

	logic                     accept;
	len_t                     eff_len;
	char_vec_t                pattern;
	char_vec_t                window_next;
	logic                     hit;
	logic [POSITION_BITS-1:0] chars_next;
	logic                     sat_next;
	logic                     take_match;
	logic                     latched_next;
	logic [POSITION_BITS-1:0] start_next;
	res_word_t                res_next;

	assign src_ready = !res_valid_q || res_ready;
	assign accept    = src_valid && src_ready;
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	assign eff_len     = (pat_len_q > len_t'(MAX_PATTERN_CHARS)) ? len_t'(MAX_PATTERN_CHARS)
	                                                              : pat_len_q;
	assign pattern     = char_vec_t'({pat_high_q, pat_low_q});
	assign window_next = {window_q[MAX_PATTERN_CHARS-2:0], src_word.source_char};

	csub_match u_match (
		.window  (window_next),
		.pattern (pattern),
		.len     (eff_len),
		.hit     (hit)
	);

	always_comb begin
		chars_next   = (chars_q == POS_MAX) ? chars_q : chars_q + POSITION_BITS'(1);
		sat_next     = sat_q || (chars_q == POS_MAX);
		take_match   = !latched_q && (eff_len != '0) &&
		               (chars_next >= POSITION_BITS'(eff_len)) && hit;
		latched_next = latched_q || take_match;
		start_next   = start_q;
		if (take_match) begin
			start_next = sat_next ? POS_MAX
			                      : chars_next - POSITION_BITS'(eff_len) + POSITION_BITS'(1);
		end
		res_next.length_overflow = sat_next;
		priority if (eff_len == '0) begin
			res_next.found          = 1'b1;
			res_next.match_position = POSITION_BITS'(1);
		end else if (latched_next) begin
			res_next.found          = 1'b1;
			res_next.match_position = start_next;
		end else begin
			res_next.found          = 1'b0;
			res_next.match_position = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH: pat_high_q <= cfg_data;
				REG_PATTERN_LEN:  pat_len_q  <= cfg_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= window_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q   <= '0;
			latched_q <= 1'b0;
			start_q   <= '0;
			sat_q     <= 1'b0;
		end else if (accept) begin
			if (src_word.last_char) begin
				chars_q   <= '0;
				latched_q <= 1'b0;
				start_q   <= '0;
				sat_q     <= 1'b0;
			end else begin
				chars_q   <= chars_next;
				latched_q <= latched_next;
				start_q   <= start_next;
				sat_q     <= sat_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && src_word.last_char) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && src_word.last_char) begin
			res_word_q <= res_next;
		end
	end

endmodule

/* design/csub_match.sv */
// Window compare: does the pattern end at the newest byte of the window.
module csub_match (
	input  csub_pkg::char_vec_t window,
	input  csub_pkg::char_vec_t pattern,
	input  csub_pkg::len_t      len,
	output logic                hit
);
	import csub_pkg::*;

	logic [IDX_BITS-1:0] idx [MAX_PATTERN_CHARS];
	len_t                off [MAX_PATTERN_CHARS];

	always_comb begin
		hit = 1'b1;
		for (int j = 0; j < MAX_PATTERN_CHARS; j++) begin
			// pattern char j lines up with window entry len-1-j (newest first)
			off[j] = len - len_t'(1) - len_t'(j);
			idx[j] = off[j][IDX_BITS-1:0];
			if ((len_t'(j) < len) && !csub_chars_equal(window[idx[j]], pattern[j])) begin
				hit = 1'b0;
			end
		end
	end

endmodule

/* design/csub_checker.sv */
// Port-level checks for the caseless substring search block, with its bind.
module csub_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                src_valid,
	input logic                src_ready,
	input csub_pkg::src_word_t src_word,
	input logic                res_valid,
	input logic                res_ready,
	input csub_pkg::res_word_t res_word
);
	import csub_pkg::*;

	// a found result always has a nonzero start, a miss always reports zero
	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.found == (res_word.match_position != '0)))
		else $error("found flag and position disagree");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready && src_word.last_char) |=> res_valid)
		else $error("no result after last byte");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready && !src_word.last_char && !res_valid) |=> !res_valid)
		else $error("result without last byte");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_word)))
		else $error("stalled result word changed");

endmodule

bind caseless_substring_search csub_checker u_csub_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_ready (src_ready),
	.src_word  (src_word),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_word  (res_word)
);

/* tb/tb_caseless_substring_search.sv */
// Testbench for caseless_substring_search: directed, backpressure and random strings.
`timescale 1ns / 1ps

module tb_caseless_substring_search;
	import csub_pkg::*;

	typedef logic [7:0] text_t[$];

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      src_valid = 1'b0;
	logic                      src_ready;
	src_word_t                 src_word = '0;
	logic                      res_valid;
	logic                      res_ready = 1'b0;
	res_word_t                 res_word;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	caseless_substring_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_word  (src_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// search state mirror
	logic [7:0]               recent [MAX_PATTERN_CHARS];
	int unsigned              bytes_counted = 0;
	bit                       hit_latched = 1'b0;
	logic [POSITION_BITS-1:0] hit_start = '0;
	bit                       counter_pinned = 1'b0;
	logic [63:0]              pat_lo = '0;
	logic [63:0]              pat_hi = '0;
	logic [4:0]               pat_len = '0;
	res_word_t                search_results_due[$];

	int gap_max = 0;
	int burst_max = 1;
	int burst_left = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int failures = 0;
	int results_checked = 0;
	int hits_checked = 0;
	res_word_t due;

	initial begin
		for (int i = 0; i < MAX_PATTERN_CHARS; i++)
			recent[i] = 8'h00;
	end

	function automatic bit is_alpha(input logic [7:0] c);
		return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A);
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return is_alpha(c) ? (c & 8'hDF) : c;
	endfunction

	function automatic logic [7:0] scramble_case(input logic [7:0] c);
		return (is_alpha(c) && $urandom_range(1)) ? (c ^ CASE_BIT) : c;
	endfunction

	function automatic logic [7:0] pattern_byte(input int j);
		return (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
	endfunction

	function automatic void advance_search(input logic [7:0] c, input logic last);
		int n;
		bit hit;
		res_word_t r;
		for (int i = MAX_PATTERN_CHARS - 1; i > 0; i--)
			recent[i] = recent[i-1];
		recent[0] = c;
		if (bytes_counted < POS_MAX)
			bytes_counted++;
		else
			counter_pinned = 1'b1;
		n = (pat_len > MAX_PATTERN_CHARS) ? MAX_PATTERN_CHARS : pat_len;
		if (!hit_latched && n > 0 && bytes_counted >= n) begin
			hit = 1'b1;
			for (int j = 0; j < n; j++)
				if (fold_case(recent[n-1-j]) != fold_case(pattern_byte(j)))
					hit = 1'b0;
			if (hit) begin
				hit_latched = 1'b1;
				hit_start = counter_pinned ? POS_MAX : POSITION_BITS'(bytes_counted - n + 1);
			end
		end
		if (last) begin
			r.found = (n == 0) || hit_latched;
			r.match_position = (n == 0) ? 16'd1 : (hit_latched ? hit_start : 16'd0);
			r.length_overflow = counter_pinned;
			search_results_due.push_back(r);
			bytes_counted = 0;
			hit_latched = 1'b0;
			hit_start = '0;
			counter_pinned = 1'b0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(gap_max, 0);
			burst_left = $urandom_range(burst_max, 1);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		src_valid <= 1'b1;
		src_word <= '{source_char: c, last_char: last};
		do @(posedge clk); while (!src_ready);
		advance_search(c, last);
		bytes_sent++;
	endtask

	task automatic send_text(input text_t s);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	task automatic wait_idle;
		@(negedge clk);
		src_valid <= 1'b0;
		burst_left = 0;
		while (search_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_PATTERN_LOW:  pat_lo = d;
			REG_PATTERN_HIGH: pat_hi = d;
			REG_PATTERN_LEN:  pat_len = d[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_pattern(input logic [127:0] b, input logic [4:0] len);
		wait_idle();
		write_reg(REG_PATTERN_LOW, b[63:0]);
		write_reg(REG_PATTERN_HIGH, b[127:64]);
		write_reg(REG_PATTERN_LEN, {59'd0, len});
	endtask

	// receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (search_results_due.size() == 0) begin
				$error("result word with none expected: found=%0d pos=%0d ovf=%0d",
					res_word.found, res_word.match_position, res_word.length_overflow);
				failures++;
			end else begin
				due = search_results_due.pop_front();
				if (res_word.found !== due.found) begin
					$error("found: expected %0d, got %0d", due.found, res_word.found);
					failures++;
				end
				if (res_word.match_position !== due.match_position) begin
					$error("match_position: expected %0d, got %0d",
						due.match_position, res_word.match_position);
					failures++;
				end
				if (res_word.length_overflow !== due.length_overflow) begin
					$error("length_overflow: expected %0d, got %0d",
						due.length_overflow, res_word.length_overflow);
					failures++;
				end
				results_checked++;
				if (due.found)
					hits_checked++;
			end
		end
	end

	task automatic test_directed;
		text_t s;
		gap_max = 2;
		burst_max = 3;
		stall_pct = 30;
		load_pattern('0, 5'd0);
		s = '{8'h51};
		send_text(s);
		load_pattern(128'h5A61, 5'd2);
		s = '{8'h61};
		send_text(s);
		s = '{8'h78, 8'h41, 8'h7A};
		send_text(s);
		// punctuation pairs one case bit apart must not match
		load_pattern(128'h5B40, 5'd2);
		s = '{8'h60, 8'h7B};
		send_text(s);
		s = '{8'h40, 8'h5B};
		send_text(s);
		load_pattern(128'hFF, 5'd1);
		s = '{8'h00, 8'hFF};
		send_text(s);
		// length above the maximum counts as full width
		load_pattern(128'h706F6E6D6C6B6A696867666564636261, 5'd31);
		s.delete();
		for (int j = 0; j < 16; j++)
			s.push_back(8'(8'h41 + j));
		send_text(s);
	endtask

	task automatic test_backpressure;
		text_t s;
		load_pattern(128'h6B, 5'd1);
		gap_max = 0;
		burst_max = 100;
		stall_pct = 0;
		@(posedge clk);
		hold_left = 400;
		repeat (60) begin
			s.delete();
			repeat ($urandom_range(3, 1))
				s.push_back($urandom_range(1) ? 8'h4B : 8'(8'h61 + $urandom_range(25)));
			send_text(s);
		end
	endtask

	task automatic test_random_strings(input int quota);
		int sent_here;
		int n;
		int pos;
		int k;
		int r;
		logic [127:0] pat;
		logic [4:0] len;
		logic [7:0] c;
		text_t s;
		sent_here = 0;
		while (sent_here < quota) begin
			case ($urandom_range(9))
				0: len = 5'd0;
				1: len = 5'd16;
				2: len = 5'($urandom_range(31, 17));
				3: len = 5'($urandom_range(15, 9));
				default: len = 5'($urandom_range(6, 1));
			endcase
			pat = {$urandom, $urandom, $urandom, $urandom};
			if ($urandom_range(1))
				for (int j = 0; j < 16; j++)
					pat[8*j +: 8] = 8'(8'h41 + $urandom_range(25) +
						($urandom_range(1) ? 8'h20 : 8'h00));
			load_pattern(pat, len);
			case ($urandom_range(2))
				0: gap_max = 0;
				1: gap_max = 2;
				default: gap_max = 8;
			endcase
			case ($urandom_range(2))
				0: burst_max = 1;
				1: burst_max = 4;
				default: burst_max = 16;
			endcase
			case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 70;
			endcase
			n = (len > MAX_PATTERN_CHARS) ? MAX_PATTERN_CHARS : len;
			repeat ($urandom_range(12, 4)) begin
				s.delete();
				repeat ($urandom_range(($urandom_range(7) == 0) ? 60 : 16, 1)) begin
					if (n > 0 && $urandom_range(99) < 55)
						s.push_back(scramble_case(pat[8*$urandom_range(n-1) +: 8]));
					else
						s.push_back(8'($urandom_range(255)));
				end
				r = $urandom_range(99);
				if (n > 0 && r < 65) begin
					// planted occurrence, broken in one byte for part of them
					pos = $urandom_range(s.size());
					k = $urandom_range(n - 1);
					for (int j = 0; j < n; j++) begin
						c = scramble_case(pat[8*j +: 8]);
						if (r >= 50 && j == k)
							c = is_alpha(c) ? (c ^ 8'h01) : (c ^ CASE_BIT);
						s.insert(pos + j, c);
					end
				end
				send_text(s);
				sent_here += s.size();
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random_strings(1800);
		wait_idle();
		repeat (20) @(posedge clk);
		if (search_results_due.size() != 0) begin
			$error("%0d result words never arrived", search_results_due.size());
			failures++;
		end
		$display("Sent %0d source bytes under bursts, gaps and receiver stalls;",
			bytes_sent);
		$display("checked %0d result words, %0d of them with a match.",
			results_checked, hits_checked);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
